>>> src/line_and_ray_rasterizer_core_defines.svh
// Assertion macros for the line and ray rasterizer checker.
// No dependencies; taken in by the checker through an include.
`ifndef LINE_AND_RAY_RASTERIZER_CORE_DEFINES_SVH
`define LINE_AND_RAY_RASTERIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define LRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define LRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/lrr_pkg.sv
// Shared constants and types of the line and ray rasterizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lrr_pkg;

    localparam int GRID_MAX   = 62;
    localparam int MAX_POINTS = 64;
    localparam int COORD_W    = 7;
    localparam int GRID_W     = 6;
    localparam int DIST_W     = 7;
    localparam int ERR_W      = 10;
    localparam int CNT_W      = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes
    localparam logic REG_GRID_COLS = 1'b0;
    localparam logic REG_GRID_ROWS = 1'b1;

    localparam logic [GRID_W-1:0] GRID_COLS_RST = GRID_W'(38);
    localparam logic [GRID_W-1:0] GRID_ROWS_RST = GRID_W'(22);

    // grid size after clamping to GRID_MAX
    typedef struct packed {
        logic [GRID_W-1:0] cols;
        logic [GRID_W-1:0] rows;
    } t_grid_cfg;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
    } t_dp_stat;

endpackage

>>> src/lrr_if.sv
// Item channels of the line and ray rasterizer: request in, point out.
// Depends on lrr_pkg for field widths.
`timescale 1ns / 1ps

interface lrr_in_if;
    import lrr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic signed [COORD_W-1:0]  src_x;
    logic signed [COORD_W-1:0]  src_y;
    logic signed [COORD_W-1:0]  aim_x;
    logic signed [COORD_W-1:0]  aim_y;
    logic signed [COORD_W-1:0]  excl_x;
    logic signed [COORD_W-1:0]  excl_y;

    modport source (output valid, kind, src_x, src_y, aim_x, aim_y, excl_x, excl_y,
                    input ready);
    modport sink   (input valid, kind, src_x, src_y, aim_x, aim_y, excl_x, excl_y,
                    output ready);
endinterface

interface lrr_out_if;
    import lrr_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  pt_x;
    logic signed [COORD_W-1:0]  pt_y;
    logic                       in_grid;
    logic                       paint;
    logic                       last;

    modport source (output valid, pt_x, pt_y, in_grid, paint, last, input ready);
    modport sink   (input valid, pt_x, pt_y, in_grid, paint, last, output ready);
endinterface

>>> src/lrr_cfg.sv
// APB register block holding the grid size of the rasterizer.
// Depends on lrr_pkg.
`timescale 1ns / 1ps

module lrr_cfg import lrr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    output t_grid_cfg              o_grid
);

    logic [GRID_W-1:0] r_grid_cols;
    logic [GRID_W-1:0] r_grid_rows;
    logic              w_wr;
    logic              w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[APB_ADDR_W-1];

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_cols <= GRID_COLS_RST;
            r_grid_rows <= GRID_ROWS_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_GRID_COLS: r_grid_cols <= pwdata[GRID_W-1:0];
                REG_GRID_ROWS: r_grid_rows <= pwdata[GRID_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            REG_GRID_COLS: prdata = APB_DATA_W'(r_grid_cols);
            REG_GRID_ROWS: prdata = APB_DATA_W'(r_grid_rows);
            default:       prdata = '0;
        endcase
    end

    // anything above GRID_MAX counts as GRID_MAX
    assign o_grid.cols = (r_grid_cols > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : r_grid_cols;
    assign o_grid.rows = (r_grid_rows > GRID_W'(GRID_MAX)) ? GRID_W'(GRID_MAX) : r_grid_rows;

endmodule

>>> src/lrr_ctrl.sv
// Controller of the rasterizer: takes an item, then walks its points out.
// Depends on lrr_pkg.
`timescale 1ns / 1ps

module lrr_ctrl import lrr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic r_state;
    logic n_state;
    logic w_in_fire;
    logic w_out_fire;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_RUN);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_out_fire  = o_out_valid && i_out_ready;

    assign o_cmd.load = w_in_fire;
    assign o_cmd.step = w_out_fire && !i_stat.last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_out_fire && i_stat.last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/lrr_dp.sv
// Datapath of the rasterizer: Bresenham stepper, inside, paint and last tests.
// Depends on lrr_pkg; driven by lrr_ctrl commands.
`timescale 1ns / 1ps

module lrr_dp import lrr_pkg::*; (
    input  logic                      i_clk,
    input  t_dp_cmd                   i_cmd,
    input  t_grid_cfg                 i_grid,
    input  logic                      i_kind,
    input  logic signed [COORD_W-1:0] i_src_x,
    input  logic signed [COORD_W-1:0] i_src_y,
    input  logic signed [COORD_W-1:0] i_aim_x,
    input  logic signed [COORD_W-1:0] i_aim_y,
    input  logic signed [COORD_W-1:0] i_excl_x,
    input  logic signed [COORD_W-1:0] i_excl_y,
    output logic signed [COORD_W-1:0] o_pt_x,
    output logic signed [COORD_W-1:0] o_pt_y,
    output logic                      o_in_grid,
    output logic                      o_paint,
    output logic                      o_last,
    output t_dp_stat                  o_stat
);

    // item registers
    logic                      r_kind;
    logic signed [COORD_W-1:0] r_src_x, r_src_y;
    logic signed [COORD_W-1:0] r_aim_x, r_aim_y;
    logic signed [COORD_W-1:0] r_excl_x, r_excl_y;
    // stepper registers
    logic signed [COORD_W-1:0] r_cur_x, r_cur_y;
    logic signed [ERR_W-1:0]   r_err;
    logic [DIST_W-1:0]         r_dx, r_dy;
    logic                      r_neg_x, r_neg_y;
    logic [CNT_W-1:0]          r_cnt;

    logic signed [COORD_W:0]   w_diff_x, w_diff_y;
    logic [DIST_W-1:0]         w_ldx, w_ldy;
    logic signed [ERR_W-1:0]   w_lerr;
    logic signed [ERR_W-1:0]   w_dx_e, w_dy_e;
    logic                      w_mv_x, w_mv_y;
    logic signed [ERR_W-1:0]   n_err;
    logic signed [COORD_W-1:0] n_cur_x, n_cur_y;
    logic                      w_in_x, w_in_y, w_inside;
    logic                      w_shadow;
    logic                      w_last;

    function automatic logic strictly_between(logic signed [COORD_W-1:0] v,
                                              logic signed [COORD_W-1:0] a,
                                              logic signed [COORD_W-1:0] b);
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v > lo) && (v < hi);
    endfunction

    // set-up of a new item: distances, directions, initial error
    assign w_diff_x = {i_aim_x[COORD_W-1], i_aim_x} - {i_src_x[COORD_W-1], i_src_x};
    assign w_diff_y = {i_aim_y[COORD_W-1], i_aim_y} - {i_src_y[COORD_W-1], i_src_y};
    assign w_ldx    = DIST_W'(w_diff_x[COORD_W] ? -w_diff_x : w_diff_x);
    assign w_ldy    = DIST_W'(w_diff_y[COORD_W] ? -w_diff_y : w_diff_y);
    assign w_lerr   = (w_ldx > w_ldy) ? ERR_W'(w_ldx[DIST_W-1:1])
                                      : ERR_W'(0) - ERR_W'(w_ldy[DIST_W-1:1]);

    // one Bresenham step
    assign w_dx_e  = ERR_W'(r_dx);
    assign w_dy_e  = ERR_W'(r_dy);
    assign w_mv_x  = r_err > -w_dx_e;
    assign w_mv_y  = r_err < w_dy_e;
    assign n_err   = r_err - (w_mv_x ? w_dy_e : ERR_W'(0)) + (w_mv_y ? w_dx_e : ERR_W'(0));
    assign n_cur_x = w_mv_x ? (r_neg_x ? r_cur_x - COORD_W'(1) : r_cur_x + COORD_W'(1))
                            : r_cur_x;
    assign n_cur_y = w_mv_y ? (r_neg_y ? r_cur_y - COORD_W'(1) : r_cur_y + COORD_W'(1))
                            : r_cur_y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_src_x  <= i_src_x;
            r_src_y  <= i_src_y;
            r_aim_x  <= i_aim_x;
            r_aim_y  <= i_aim_y;
            r_excl_x <= i_excl_x;
            r_excl_y <= i_excl_y;
            r_cur_x  <= i_src_x;
            r_cur_y  <= i_src_y;
            r_dx     <= w_ldx;
            r_dy     <= w_ldy;
            r_neg_x  <= w_diff_x[COORD_W] || (w_diff_x == '0);
            r_neg_y  <= w_diff_y[COORD_W] || (w_diff_y == '0);
            r_err    <= w_lerr;
            r_cnt    <= '0;
        end else if (i_cmd.step) begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_err    <= n_err;
            r_cnt    <= r_cnt + CNT_W'(1);
        end
    end

    // inside test: non-negative and below the clamped grid size
    assign w_in_x   = !r_cur_x[COORD_W-1] && (r_cur_x[GRID_W-1:0] < i_grid.cols);
    assign w_in_y   = !r_cur_y[COORD_W-1] && (r_cur_y[GRID_W-1:0] < i_grid.rows);
    assign w_inside = w_in_x && w_in_y;

    // ray shadow between source and exclusion corner
    assign w_shadow = strictly_between(r_cur_x, r_src_x, r_excl_x) ||
                      strictly_between(r_cur_y, r_src_y, r_excl_y);

    // end of item: aim reached, ray left grid or has no length, or point cap
    always_comb begin
        if (r_kind) begin
            w_last = !w_inside || ((r_dx == '0) && (r_dy == '0));
        end else begin
            w_last = (r_cur_x == r_aim_x) && (r_cur_y == r_aim_y);
        end
        if (r_cnt == CNT_W'(MAX_POINTS - 1)) w_last = 1'b1;
    end

    assign o_pt_x      = r_cur_x;
    assign o_pt_y      = r_cur_y;
    assign o_in_grid   = w_inside;
    assign o_paint     = w_inside && !(r_kind && w_shadow);
    assign o_last      = w_last;
    assign o_stat.last = w_last;

endmodule

>>> src/line_and_ray_rasterizer_core.sv
// Line and ray rasterizer: request in, one point per cycle out when ready.
// Built from lrr_cfg, lrr_ctrl and lrr_dp; uses lrr_pkg and lrr_if.
//
// Usage:
//   i_in takes one request (kind, source, aim, exclusion corner) while the
//   block is idle. The first point is valid on o_out the cycle after the
//   request is taken, then one point per cycle while o_out.ready is high.
//   The final point of the item carries last; the block is ready for the
//   next request in the cycle after that point is taken.
//   Points come from the single Bresenham stepper in the datapath, which
//   advances once per point taken; an item has at most 64 points.
//   When the receiver stalls, the point on o_out is held unchanged and the
//   stepper waits. The grid size comes from the APB registers grid_cols
//   (address 0) and grid_rows (address 4); write them only while idle.
//   Reset (synchronous, active low) returns the block to idle with the
//   grid set to 38 columns by 22 rows; no point is pending after reset.
`timescale 1ns / 1ps

module line_and_ray_rasterizer_core import lrr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    lrr_in_if.sink                 i_in,
    lrr_out_if.source              o_out,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    t_grid_cfg w_grid;
    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;

    // configuration registers
    lrr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_grid  (w_grid)
    );

    // handshake and sequencing
    lrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // stepper and point flags
    lrr_dp u_dp (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .i_grid    (w_grid),
        .i_kind    (i_in.kind),
        .i_src_x   (i_in.src_x),
        .i_src_y   (i_in.src_y),
        .i_aim_x   (i_in.aim_x),
        .i_aim_y   (i_in.aim_y),
        .i_excl_x  (i_in.excl_x),
        .i_excl_y  (i_in.excl_y),
        .o_pt_x    (o_out.pt_x),
        .o_pt_y    (o_out.pt_y),
        .o_in_grid (o_out.in_grid),
        .o_paint   (o_out.paint),
        .o_last    (o_out.last),
        .o_stat    (w_stat)
    );

endmodule

>>> src/lrr_checker.sv
// Port-level checks of the line and ray rasterizer, bound to the top level.
// Depends on lrr_pkg and line_and_ray_rasterizer_core_defines.svh.
`timescale 1ns / 1ps
`include "line_and_ray_rasterizer_core_defines.svh"

module lrr_checker import lrr_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [COORD_W-1:0] i_pt_x,
    input logic signed [COORD_W-1:0] i_pt_y,
    input logic                      i_last
);

    // a stalled point is held
    `LRR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pt_x) && $stable(i_pt_y) && $stable(i_last), "stalled point changed")

    // one item at a time: no request taken while points are pending
    `LRR_ASSERT_NOW(a_one_item, i_clk, i_rst_n, i_in_ready, !i_out_valid, "ready while a point is pending")

    // the first point follows a taken request at once
    `LRR_ASSERT_NEXT(a_first_pt, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid && !i_in_ready, "no point after request")

    // after the final point the block is idle again
    `LRR_ASSERT_NEXT(a_back_idle, i_clk, i_rst_n, i_out_valid && i_out_ready && i_last, i_in_ready && !i_out_valid, "not idle after last point")

endmodule

bind line_and_ray_rasterizer_core lrr_checker u_lrr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_pt_x      (o_out.pt_x),
    .i_pt_y      (o_out.pt_y),
    .i_last      (o_out.last)
);

>>> tb/tb_line_and_ray_rasterizer_core.sv
// Self-checking testbench for line_and_ray_rasterizer_core: Bresenham segments and rays.
// Needs lrr_pkg, lrr_in_if and lrr_out_if from the RTL; drives the APB grid registers too.
`timescale 1ns / 1ps

module tb_line_and_ray_rasterizer_core;
    import lrr_pkg::*;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_RAY     = 1'b1;
    localparam int   LINE_CYCLES  = 65;     // longest item: 64 points and its request
    localparam int   STALL_LIMIT  = 2000;   // cycles with no item moving before giving up

    typedef struct packed {
        logic                kind;
        logic [COORD_W-1:0]  src_x;
        logic [COORD_W-1:0]  src_y;
        logic [COORD_W-1:0]  aim_x;
        logic [COORD_W-1:0]  aim_y;
        logic [COORD_W-1:0]  excl_x;
        logic [COORD_W-1:0]  excl_y;
    } t_line_req;

    typedef struct packed {
        logic [COORD_W-1:0]  pt_x;
        logic [COORD_W-1:0]  pt_y;
        logic                in_grid;
        logic                paint;
        logic                last;
    } t_point;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    lrr_in_if  req_if ();
    lrr_out_if pt_if ();

    line_and_ray_rasterizer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (pt_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the grid registers
    logic [GRID_W-1:0] cols_setting;
    logic [GRID_W-1:0] rows_setting;

    t_point pending_points[$];
    int     mismatch_count = 0;
    int     quiet_cycles   = 0;
    bit     calm           = 1'b0;   // no gaps and no stalls while set
    int     stall_left     = 0;

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly none, sometimes short, rarely long
    function automatic int rand_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic bit strictly_between(int v, int a, int b);
        int lo;
        int hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v > lo) && (v < hi);
    endfunction

    // Bresenham walk of one request; queues every point it should produce
    function automatic void trace_line(input t_line_req req);
        int sx0, sy0, ax, ay, ex, ey;
        int dx, dy, stx, sty, err, e, px, py, cols, rows, n;
        logic is_ray, on_grid, paint, last;
        t_point pt;
        is_ray = (req.kind == KIND_RAY);
        sx0 = $signed(req.src_x);
        sy0 = $signed(req.src_y);
        ax  = $signed(req.aim_x);
        ay  = $signed(req.aim_y);
        ex  = $signed(req.excl_x);
        ey  = $signed(req.excl_y);
        cols = (cols_setting > GRID_MAX) ? GRID_MAX : cols_setting;
        rows = (rows_setting > GRID_MAX) ? GRID_MAX : rows_setting;
        dx  = (ax > sx0) ? ax - sx0 : sx0 - ax;
        dy  = (ay > sy0) ? ay - sy0 : sy0 - ay;
        stx = (sx0 < ax) ? 1 : -1;
        sty = (sy0 < ay) ? 1 : -1;
        err = (dx > dy) ? dx / 2 : -(dy / 2);
        px  = sx0;
        py  = sy0;
        n   = 0;
        last = 1'b0;
        while (!last) begin
            on_grid = (px >= 0) && (px < cols) && (py >= 0) && (py < rows);
            paint   = on_grid;
            // rays leave points strictly between source and exclusion corner in x or in y unpainted
            if (is_ray && on_grid)
                paint = !strictly_between(px, sx0, ex) && !strictly_between(py, sy0, ey);
            if (is_ray)
                last = !on_grid || (dx == 0 && dy == 0);
            else
                last = (px == ax) && (py == ay);
            if (n == MAX_POINTS - 1)
                last = 1'b1;
            pt.pt_x    = COORD_W'(px);
            pt.pt_y    = COORD_W'(py);
            pt.in_grid = on_grid;
            pt.paint   = paint;
            pt.last    = last;
            pending_points.push_back(pt);
            n++;
            if (!last) begin
                e = err;
                if (e > -dx) begin
                    err -= dy;
                    px  += stx;
                end
                if (e < dy) begin
                    err += dx;
                    py  += sty;
                end
            end
        end
    endfunction

    function automatic t_line_req mk_req(logic kind, int sx, int sy, int ax, int ay,
                                         int ex, int ey);
        t_line_req r;
        r.kind   = kind;
        r.src_x  = COORD_W'(sx);
        r.src_y  = COORD_W'(sy);
        r.aim_x  = COORD_W'(ax);
        r.aim_y  = COORD_W'(ay);
        r.excl_x = COORD_W'(ex);
        r.excl_y = COORD_W'(ey);
        return r;
    endfunction

    // Send one request; the expected points are queued when it is taken
    task automatic send_request(input t_line_req req);
        int gap;
        gap = calm ? 0 : rand_pause();
        @(negedge i_clk);
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.kind   = req.kind;
        req_if.src_x  = req.src_x;
        req_if.src_y  = req.src_y;
        req_if.aim_x  = req.aim_x;
        req_if.aim_y  = req.aim_y;
        req_if.excl_x = req.excl_x;
        req_if.excl_y = req.excl_y;
        req_if.valid  = 1'b1;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        trace_line(req);
    endtask

    task automatic draw(logic kind, int sx, int sy, int ax, int ay, int ex, int ey);
        send_request(mk_req(kind, sx, sy, ax, ay, ex, ey));
    endtask

    // Lower valid and let every queued point drain
    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (LINE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (idx == REG_GRID_COLS)
            cols_setting = data[GRID_W-1:0];
        else
            rows_setting = data[GRID_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input logic idx);
        logic [APB_DATA_W-1:0] want;
        want = (idx == REG_GRID_COLS) ? APB_DATA_W'(cols_setting) : APB_DATA_W'(rows_setting);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: register %0d read: expected %0d actual %0d",
                     $realtime, idx, want, prdata);
            mismatch_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Change the grid while idle; upper data bits carry junk
    task automatic set_grid(int cols, int rows);
        logic [APB_DATA_W-1:0] data;
        wait_drained();
        data = $urandom;
        data[GRID_W-1:0] = GRID_W'(cols);
        apb_write(REG_GRID_COLS, data);
        data = $urandom;
        data[GRID_W-1:0] = GRID_W'(rows);
        apb_write(REG_GRID_ROWS, data);
        apb_read_check(REG_GRID_COLS);
        apb_read_check(REG_GRID_ROWS);
    endtask

    function automatic int coord_on_grid(int limit);
        if (limit == 0)
            return $urandom_range(0, GRID_MAX);
        return $urandom_range(0, limit - 1);
    endfunction

    // Mostly sources inside the grid so rays walk far; some pure noise
    function automatic t_line_req rand_request();
        t_line_req r;
        int ec, er, pick, sx, sy;
        ec = (cols_setting > GRID_MAX) ? GRID_MAX : cols_setting;
        er = (rows_setting > GRID_MAX) ? GRID_MAX : rows_setting;
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            r = t_line_req'($urandom);
            r.src_x = COORD_W'($urandom);
            r.src_y = COORD_W'($urandom);
            return r;
        end
        sx = (pick == 1) ? int'($urandom_range(0, 63)) - 1 : coord_on_grid(ec);
        sy = (pick == 2) ? int'($urandom_range(0, 63)) - 1 : coord_on_grid(er);
        r.kind  = 1'($urandom_range(0, 1));
        r.src_x = COORD_W'(sx);
        r.src_y = COORD_W'(sy);
        if ($urandom_range(0, 1)) begin
            r.aim_x = COORD_W'(sx + int'($urandom_range(0, 12)) - 6);
            r.aim_y = COORD_W'(sy + int'($urandom_range(0, 12)) - 6);
        end else begin
            r.aim_x = COORD_W'(int'($urandom_range(0, 63)) - 1);
            r.aim_y = COORD_W'(int'($urandom_range(0, 63)) - 1);
        end
        r.excl_x = COORD_W'(int'($urandom_range(0, 63)) - 1);
        r.excl_y = COORD_W'(int'($urandom_range(0, 63)) - 1);
        return r;
    endfunction

    // Receiver: random back-pressure on the point channel
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            pt_if.ready = 1'b0;
            stall_left--;
        end else begin
            pt_if.ready = 1'b1;
            if (!calm)
                stall_left = rand_pause();
        end
    end

    function automatic void check_field(string name, logic [COORD_W-1:0] want,
                                        logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s: expected %0d actual %0d",
                     $realtime, name, $signed(want), $signed(got));
            mismatch_count++;
        end
    endfunction

    // Point checker
    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && pt_if.valid && pt_if.ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t: point (%0d,%0d) with nothing expected",
                         $realtime, $signed(pt_if.pt_x), $signed(pt_if.pt_y));
                mismatch_count++;
            end else begin
                want = pending_points.pop_front();
                check_field("pt_x", want.pt_x, pt_if.pt_x);
                check_field("pt_y", want.pt_y, pt_if.pt_y);
                check_field("in_grid", COORD_W'(want.in_grid), COORD_W'(pt_if.in_grid));
                check_field("paint", COORD_W'(want.paint), COORD_W'(pt_if.paint));
                check_field("last", COORD_W'(want.last), COORD_W'(pt_if.last));
            end
        end
    end

    // Watchdog on items moving
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (pt_if.valid && pt_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Registers come up at 38 by 22
    task automatic test_reset_values();
        apb_read_check(REG_GRID_COLS);
        apb_read_check(REG_GRID_ROWS);
    endtask

    task automatic test_segments();
        draw(KIND_SEGMENT, 5, 5, 5, 5, 0, 0);          // single point
        draw(KIND_SEGMENT, 0, 0, 10, 0, 3, 3);         // horizontal
        draw(KIND_SEGMENT, 10, 3, 0, 3, 0, 0);         // leftwards
        draw(KIND_SEGMENT, 2, 0, 2, 21, 0, 0);         // vertical to the last row
        draw(KIND_SEGMENT, 20, 15, 8, 4, 9, 9);        // shallow, both signs negative
        draw(KIND_SEGMENT, 3, 1, 7, 13, 0, 0);         // steep
        draw(KIND_SEGMENT, -1, -1, 62, 62, 62, -1);    // corner to corner, 64 points
        draw(KIND_SEGMENT, -64, 10, 63, -20, -64, 63); // too long: cut at 64 points
        draw(KIND_SEGMENT, 63, 63, -64, -64, 0, 0);
    endtask

    task automatic test_rays();
        draw(KIND_RAY, 4, 4, 4, 4, 0, 0);              // zero length inside
        draw(KIND_RAY, -1, 5, -1, 5, 0, 0);            // zero length outside
        draw(KIND_RAY, 40, 3, 0, 3, 0, 0);             // starts outside
        draw(KIND_RAY, 0, 0, 1, 1, 5, 5);
        draw(KIND_RAY, 37, 21, 36, 20, 30, 25);
        draw(KIND_RAY, 10, 10, 10, 0, 12, 3);
        draw(KIND_RAY, 10, 10, 30, 12, 0, 0);
        draw(KIND_RAY, 5, 20, 6, -1, 5, 20);           // corner on the source
        draw(KIND_RAY, 0, 0, 62, 62, 62, 62);          // aim beyond the grid
    endtask

    task automatic test_grid_settings();
        set_grid(63, 62);                              // above the maximum: clamped
        draw(KIND_RAY, 0, 0, 1, 0, -1, -1);
        draw(KIND_RAY, 0, 0, 0, 1, -1, -1);
        set_grid(0, 0);                                // nothing inside
        draw(KIND_RAY, 0, 0, 1, 1, 0, 0);
        draw(KIND_SEGMENT, 0, 0, 3, 2, 0, 0);
        set_grid(1, 1);
        draw(KIND_RAY, 0, 0, 1, 0, 0, 0);
        draw(KIND_SEGMENT, -1, -1, 1, 1, 0, 0);
    endtask

    task automatic test_random();
        int phase;
        int k;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_grid($urandom_range(1, GRID_MAX), $urandom_range(1, GRID_MAX));
                1: set_grid(GRID_MAX, GRID_MAX);
                2: set_grid($urandom_range(1, 6), $urandom_range(1, 6));
                3: set_grid(63, $urandom_range(30, 63));
                default: set_grid(38, 22);
            endcase
            calm = (phase == 1);
            for (k = 0; k < 29; k++)
                send_request(rand_request());
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        req_if.valid  = 1'b0;
        req_if.kind   = KIND_SEGMENT;
        req_if.src_x  = '0;
        req_if.src_y  = '0;
        req_if.aim_x  = '0;
        req_if.aim_y  = '0;
        req_if.excl_x = '0;
        req_if.excl_y = '0;
        pt_if.ready   = 1'b0;
        cols_setting  = GRID_COLS_RST;
        rows_setting  = GRID_ROWS_RST;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_segments();
        test_rays();
        test_grid_settings();
        test_random();

        wait_drained();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/lrr_pkg.sv
src/lrr_if.sv
src/lrr_cfg.sv
src/lrr_ctrl.sv
src/lrr_dp.sv
src/line_and_ray_rasterizer_core.sv
src/lrr_checker.sv
tb/tb_line_and_ray_rasterizer_core.sv
